/* hdl/trd_pkg.sv */
// Package for the TGA run-length pixel decoder.
// Holds the shared types, register indexes and sizes; no dependencies.
package trd_pkg;

  localparam int BPP_MAX   = 4;
  localparam int IDX_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 16;
  localparam int TOTAL_W   = 32;

  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [6:0] COUNT_MASK = 7'h7f;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RLE_MODE        = 2'd0,
    REG_BYTES_PER_PIXEL = 2'd1,
    REG_IMAGE_WIDTH     = 2'd2,
    REG_IMAGE_HEIGHT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                 rle_mode;
    logic [2:0]           bytes_per_pixel;
    logic [TOTAL_W-1:0]   total;
  } cfg_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [7:0] repeat_res;
    logic       last;
  } pix_t;

endpackage

/* hdl/tga_rle_pixel_decoder.sv */
// Decodes the pixel-data bytes of a true-color TGA image, raw or run-length
// encoded, into pixels with a repeat count and a last flag. One byte request
// is accepted every clock while in_stall is low. Each byte passes the input
// register, and the pixel that it completes then waits in the result register
// until the consumer takes it. The loop through the packet and pixel counters
// sets this rate. Bytes after the image is complete are accepted and dropped
// until reset or until a larger image size is written. Depends on trd_pkg,
// trd_cfg, trd_decode and trd_out.
module tga_rle_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trd_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_chan0,
  output logic [7:0]                    out_chan1,
  output logic [7:0]                    out_chan2,
  output logic [7:0]                    out_chan3,
  output logic [7:0]                    out_repeat_res,
  output logic                          out_last
);

  trd_pkg::cfg_t cfg;
  trd_pkg::pix_t res;
  trd_pkg::pix_t out_pix;
  logic          res_valid;
  logic          res_ready;

  trd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  trd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  assign out_chan0      = out_pix.chan0;
  assign out_chan1      = out_pix.chan1;
  assign out_chan2      = out_pix.chan2;
  assign out_chan3      = out_pix.chan3;
  assign out_repeat_res = out_pix.repeat_res;
  assign out_last       = out_pix.last;

endmodule

/* hdl/trd_cfg.sv */
// Configuration registers of the TGA decoder, including the pixel total.
// Depends on trd_pkg.
module trd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trd_pkg::CFG_DW-1:0]     cfg_data,
  output trd_pkg::cfg_t                  cfg
);

  logic                          rle_mode_r, rle_mode_nxt;
  logic [2:0]                    bpp_r, bpp_nxt;
  logic [15:0]                   width_r, width_nxt;
  logic [15:0]                   height_r, height_nxt;
  logic [trd_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic [15:0]                   mul_a, mul_b;

  // The total is refreshed in the same edge as a size write, from the new value.
  always_comb begin
    rle_mode_nxt = rle_mode_r;
    bpp_nxt      = bpp_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    if (cfg_we) begin
      unique case (trd_pkg::reg_idx_t'(cfg_index))
        trd_pkg::REG_RLE_MODE:        rle_mode_nxt = cfg_data[0];
        trd_pkg::REG_BYTES_PER_PIXEL: bpp_nxt      = cfg_data[2:0];
        trd_pkg::REG_IMAGE_WIDTH:     width_nxt    = cfg_data;
        trd_pkg::REG_IMAGE_HEIGHT:    height_nxt   = cfg_data;
        default: ;
      endcase
    end
    mul_a     = width_nxt;
    mul_b     = height_nxt;
    total_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r <= 1'b0;
      bpp_r      <= 3'd3;
      width_r    <= '0;
      height_r   <= '0;
      total_r    <= '0;
    end else begin
      rle_mode_r <= rle_mode_nxt;
      bpp_r      <= bpp_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      total_r    <= total_nxt;
    end
  end

  assign cfg.rle_mode        = rle_mode_r;
  assign cfg.bytes_per_pixel = bpp_r;
  assign cfg.total           = total_r;

endmodule

/* hdl/trd_decode.sv */
// Input register and packet/pixel decode state of the TGA decoder.
// Depends on trd_pkg; feeds the result register in trd_out.
module trd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  trd_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  output logic              in_stall,
  input  logic              res_ready,
  output logic              res_valid,
  output trd_pkg::pix_t     res
);

  logic                          vld_r, vld_nxt;
  logic [7:0]                    byte_r;
  logic                          expect_header_r, expect_header_nxt;
  logic                          is_run_r, is_run_nxt;
  logic [7:0]                    left_r, left_nxt;
  logic [trd_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [7:0]                    pb_r   [trd_pkg::BPP_MAX];
  logic [7:0]                    pb_nxt [trd_pkg::BPP_MAX];
  logic [trd_pkg::TOTAL_W-1:0]   done_r, done_nxt;

  logic                          advance;
  logic                          finished;
  logic [2:0]                    bpp;
  logic [trd_pkg::TOTAL_W-1:0]   remaining;
  logic [7:0]                    rep, rep_clip;
  logic                          emit;

  assign advance  = vld_r && res_ready;
  assign in_stall = vld_r && !res_ready;
  assign vld_nxt  = (in_valid && !in_stall) ? 1'b1 : (advance ? 1'b0 : vld_r);

  always_comb begin
    if (cfg.bytes_per_pixel == 3'd0)        bpp = 3'd1;
    else if (cfg.bytes_per_pixel > 3'd4)    bpp = 3'(trd_pkg::BPP_MAX);
    else                                    bpp = cfg.bytes_per_pixel;
  end

  assign finished  = done_r >= cfg.total;
  assign remaining = cfg.total - done_r;

  always_comb begin
    expect_header_nxt = expect_header_r;
    is_run_nxt        = is_run_r;
    left_nxt          = left_r;
    idx_nxt           = idx_r;
    done_nxt          = done_r;
    for (int i = 0; i < trd_pkg::BPP_MAX; i++) pb_nxt[i] = pb_r[i];
    emit     = 1'b0;
    rep      = 8'd1;
    rep_clip = 8'd1;

    if (advance && !finished) begin
      if (cfg.rle_mode && expect_header_r) begin
        is_run_nxt        = (byte_r & trd_pkg::RUN_FLAG) != 8'd0;
        left_nxt          = {1'b0, byte_r[6:0] & trd_pkg::COUNT_MASK} + 8'd1;
        expect_header_nxt = 1'b0;
        idx_nxt           = '0;
      end else begin
        pb_nxt[idx_r] = byte_r;
        if ({1'b0, idx_r} + 3'd1 < bpp) begin
          idx_nxt = idx_r + 2'd1;
        end else begin
          idx_nxt = '0;
          emit    = 1'b1;
          if (cfg.rle_mode) begin
            if (is_run_r) begin
              rep      = (left_r != 8'd0) ? left_r : 8'd1;
              left_nxt = 8'd0;
            end else begin
              left_nxt = (left_r > 8'd1) ? left_r - 8'd1 : 8'd0;
            end
            if (left_nxt == 8'd0) expect_header_nxt = 1'b1;
          end
          rep_clip = ({24'd0, rep} > remaining) ? remaining[7:0] : rep;
          done_nxt = done_r + {24'd0, rep_clip};
        end
      end
    end
  end

  // Channel ordering: three-byte pixels arrive as BGR and leave as RGB.
  always_comb begin
    res.chan0      = (bpp == 3'd3) ? pb_nxt[2] : pb_nxt[0];
    res.chan1      = (bpp >= 3'd2) ? pb_nxt[1] : 8'd0;
    res.chan2      = (bpp == 3'd3) ? pb_nxt[0] : ((bpp >= 3'd3) ? pb_nxt[2] : 8'd0);
    res.chan3      = (bpp >= 3'd4) ? pb_nxt[3] : 8'd0;
    res.repeat_res = rep_clip;
    res.last       = {24'd0, rep} >= remaining;
  end

  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) byte_r <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r           <= 1'b0;
      expect_header_r <= 1'b1;
      is_run_r        <= 1'b0;
      left_r          <= '0;
      idx_r           <= '0;
      done_r          <= '0;
      for (int i = 0; i < trd_pkg::BPP_MAX; i++) pb_r[i] <= '0;
    end else begin
      vld_r           <= vld_nxt;
      expect_header_r <= expect_header_nxt;
      is_run_r        <= is_run_nxt;
      left_r          <= left_nxt;
      idx_r           <= idx_nxt;
      done_r          <= done_nxt;
      for (int i = 0; i < trd_pkg::BPP_MAX; i++) pb_r[i] <= pb_nxt[i];
    end
  end

endmodule

/* hdl/trd_out.sv */
// Result register of the TGA decoder, holding one pixel for the consumer.
// Depends on trd_pkg.
module trd_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  trd_pkg::pix_t  res,
  output logic           res_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output trd_pkg::pix_t  out_pix
);

  logic          valid_r, valid_nxt;
  trd_pkg::pix_t pix_r;

  assign res_ready = !valid_r || !out_stall;
  assign valid_nxt = res_valid ? 1'b1 : (res_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid) pix_r <= res;
  end

  assign out_valid = valid_r;
  assign out_pix   = pix_r;

endmodule

/* hdl/trd_checker.sv */
// Port-level checks for the TGA decoder, bound to the top level.
// Depends only on the top level's ports.
module trd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_repeat_res
);

  // A held pixel must stay until the consumer takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // Every pixel stands for one to one hundred twenty-eight copies.
  a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_res != 8'd0) && (out_repeat_res <= 8'd128))
    else $error("repeat count out of range");

  // With the result register empty, the input side never back-pressures.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register is empty");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_repeat_res (out_repeat_res)
);

/* tb/testbench.sv */
// Self-checking bench for tga_rle_pixel_decoder: directed and random byte streams, raw and
// run-length, with a built-in decoder that predicts every pixel, checked as results come out.
// Depends on trd_pkg and the decoder RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 2000;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 8;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [trd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [trd_pkg::CFG_DW-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_data_byte = 8'h00;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_chan0, out_chan1, out_chan2, out_chan3, out_repeat_res;
  logic                          out_last;

  tga_rle_pixel_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_chan0(out_chan0), .out_chan1(out_chan1), .out_chan2(out_chan2),
    .out_chan3(out_chan3), .out_repeat_res(out_repeat_res), .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies as the decoder sees them.
  logic        mode_q = 1'b0;
  logic [2:0]  bpp_q = 3'd3;
  logic [15:0] width_q = '0;
  logic [15:0] height_q = '0;

  // Decoder state mirrored by the prediction.
  logic        hdr_pending = 1'b1;
  logic        run_packet = 1'b0;
  logic [7:0]  pkt_left = '0;
  logic [1:0]  byte_pos = '0;
  logic [7:0]  pix_buf [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [31:0] pix_count = '0;

  logic [7:0]     byte_stream [$];
  trd_pkg::pix_t  pending_pixels [$];
  int             live_bytes = 0;
  int             mismatches = 0;
  int             src_idle_pct = 32;
  int             snk_idle_pct = 75;
  int             cycles = 0;

  function automatic int pixel_width();
    if (bpp_q == 3'd0) return 1;
    if (int'(bpp_q) > trd_pkg::BPP_MAX) return trd_pkg::BPP_MAX;
    return int'(bpp_q);
  endfunction

  // Runs one accepted byte through the decoder and queues the pixel it completes, if any.
  task automatic decode_byte(input logic [7:0] d);
    logic [31:0]   total, remaining, rep;
    int            w;
    trd_pkg::pix_t p;
    total = {16'h0000, width_q} * {16'h0000, height_q};
    if (pix_count >= total) return;
    live_bytes++;
    if (mode_q && hdr_pending) begin
      run_packet  = d[7];
      pkt_left    = {1'b0, d[6:0]} + 8'd1;
      hdr_pending = 1'b0;
      byte_pos    = '0;
      return;
    end
    w = pixel_width();
    pix_buf[byte_pos] = d;
    if (int'(byte_pos) + 1 < w) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    byte_pos = '0;
    rep = 32'd1;
    if (mode_q) begin
      if (run_packet) begin
        rep = (pkt_left != 8'd0) ? {24'h0, pkt_left} : 32'd1;
        pkt_left = '0;
      end else if (pkt_left > 8'd1) begin
        pkt_left = pkt_left - 8'd1;
      end else begin
        pkt_left = '0;
      end
      if (pkt_left == 8'd0) hdr_pending = 1'b1;
    end
    remaining = total - pix_count;
    if (rep > remaining) rep = remaining;
    pix_count = pix_count + rep;
    // Three-byte pixels arrive as BGR and leave as RGB.
    p.chan0      = (w == 3) ? pix_buf[2] : pix_buf[0];
    p.chan1      = (w >= 2) ? pix_buf[1] : 8'h00;
    p.chan2      = (w == 3) ? pix_buf[0] : ((w >= 3) ? pix_buf[2] : 8'h00);
    p.chan3      = (w >= 4) ? pix_buf[3] : 8'h00;
    p.repeat_res = rep[7:0];
    p.last       = (pix_count >= total);
    pending_pixels.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Byte driver: predicts each accepted request, then offers the next byte or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte);
      if (!in_valid || !in_stall) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= byte_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor with random back-pressure.
  always @(posedge clk) begin
    trd_pkg::pix_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: pixel expected none actual %0h %0h %0h %0h rep %0d last %0b", $time,
                   out_chan0, out_chan1, out_chan2, out_chan3, out_repeat_res, out_last);
        end else begin
          want = pending_pixels.pop_front();
          check_field("chan0", want.chan0, out_chan0);
          check_field("chan1", want.chan1, out_chan1);
          check_field("chan2", want.chan2, out_chan2);
          check_field("chan3", want.chan3, out_chan3);
          check_field("repeat_res", want.repeat_res, out_repeat_res);
          check_field("last", {7'h00, want.last}, {7'h00, out_last});
        end
      end
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic set_reg(input trd_pkg::reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      trd_pkg::REG_RLE_MODE:        mode_q = val[0];
      trd_pkg::REG_BYTES_PER_PIXEL: bpp_q = val[2:0];
      trd_pkg::REG_IMAGE_WIDTH:     width_q = val;
      trd_pkg::REG_IMAGE_HEIGHT:    height_q = val;
      default: ;
    endcase
  endtask

  // Waits until every byte is taken and every predicted pixel has come out. Sampling at the
  // falling edge sees the driver's updates settled; the extra cycles flush a trailing byte
  // that completes no pixel.
  task automatic drain();
    while (byte_stream.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [6:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(7));
    if (r < 92) return 7'($urandom_range(31, 8));
    return 7'($urandom_range(127, 32));
  endfunction

  // One setting of the registers followed by a stream of packets. The size is chosen so the
  // image usually ends within the stream; state carries over from the previous setting.
  task automatic random_phase();
    longint      goal;
    int          w, h, budget, n, npix;
    logic [7:0]  hdr;
    set_reg(trd_pkg::REG_RLE_MODE, ($urandom_range(99) < 65) ? 16'd1 : 16'd0);
    if ($urandom_range(99) < 80)
      set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'($urandom_range(4, 1)));
    else set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'($urandom_range(7)));
    case ($urandom_range(9))
      0: begin
        if ($urandom_range(1) != 0) begin
          w = 0;
          h = $urandom_range(65535);
        end else begin
          w = $urandom_range(65535);
          h = 0;
        end
      end
      1: begin
        w = 65535;
        h = $urandom_range(65535, 1);
      end
      default: begin
        goal = longint'(pix_count) + $urandom_range(160, 1);
        h = int'((goal + 65534) / 65535) + $urandom_range(2);
        w = int'((goal + h - 1) / h);
      end
    endcase
    if ($urandom_range(1) != 0) begin
      set_reg(trd_pkg::REG_IMAGE_WIDTH, 16'(w));
      set_reg(trd_pkg::REG_IMAGE_HEIGHT, 16'(h));
    end else begin
      set_reg(trd_pkg::REG_IMAGE_WIDTH, 16'(h));
      set_reg(trd_pkg::REG_IMAGE_HEIGHT, 16'(w));
    end
    budget = $urandom_range(96, 8);
    n = 0;
    while (n < budget) begin
      // Mostly well-formed packets in RLE mode; else stray bytes, which shift RLE framing.
      if (mode_q && $urandom_range(99) >= 8) begin
        hdr = {($urandom_range(1) != 0), rand_count()};
        byte_stream.push_back(hdr);
        npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
        repeat (npix * pixel_width()) byte_stream.push_back(rand_byte());
        n += 1 + npix * pixel_width();
      end else begin
        byte_stream.push_back(rand_byte());
        n++;
      end
    end
    drain();
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty image out of reset: everything is dropped.
    byte_stream.push_back(8'h00); byte_stream.push_back(8'hff);
    drain();

    // Raw three-byte pixels with the BGR swap.
    set_reg(trd_pkg::REG_IMAGE_WIDTH, 16'd2);
    set_reg(trd_pkg::REG_IMAGE_HEIGHT, 16'd2);
    byte_stream.push_back(8'h00); byte_stream.push_back(8'hff); byte_stream.push_back(8'h5a);
    byte_stream.push_back(8'hff); byte_stream.push_back(8'h00); byte_stream.push_back(8'ha5);
    drain();

    // A full-length run clipped to the two pixels left, then a byte past the end.
    set_reg(trd_pkg::REG_RLE_MODE, 16'd1);
    set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'd1);
    byte_stream.push_back(8'hff); byte_stream.push_back(8'h81); byte_stream.push_back(8'h3c);
    drain();

    // Largest image; a four-byte literal left half done, then the depth is lowered.
    set_reg(trd_pkg::REG_IMAGE_WIDTH, 16'hffff);
    set_reg(trd_pkg::REG_IMAGE_HEIGHT, 16'hffff);
    set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'd4);
    byte_stream.push_back(8'h00); byte_stream.push_back(8'h11); byte_stream.push_back(8'h22);
    drain();
    set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'd2);
    byte_stream.push_back(8'h33);
    drain();

    // Depth codes above and below the legal range.
    set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'd7);
    byte_stream.push_back(8'h80); byte_stream.push_back(8'hde); byte_stream.push_back(8'had);
    byte_stream.push_back(8'hbe); byte_stream.push_back(8'hef);
    drain();
    set_reg(trd_pkg::REG_BYTES_PER_PIXEL, 16'd0);
    byte_stream.push_back(8'h7f); byte_stream.push_back(8'hfe);
    drain();

    base = live_bytes;
    while (live_bytes - base < RANDOM_BYTES) begin
      if (live_bytes - base < RANDOM_BYTES / 3) begin
        src_idle_pct = 32;
        snk_idle_pct = 75;
      end else if (live_bytes - base < 2 * RANDOM_BYTES / 3) begin
        src_idle_pct = 75;
        snk_idle_pct = 32;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_phase();
    end

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/trd_pkg.sv
hdl/trd_cfg.sv
hdl/trd_decode.sv
hdl/trd_out.sv
hdl/tga_rle_pixel_decoder.sv
hdl/trd_checker.sv
tb/testbench.sv
